// ----- hw/rtl/integer_to_radix_digits_macros.svh -----
// Assertion macros shared by the radix digit converter modules.
`ifndef INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ITRD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ITRD_NEVER(lbl, cond, msg) \
	`ITRD_ASSERT(lbl, !(cond), msg)

`endif

// ----- hw/rtl/itrd_pkg.sv -----
// Shared constants, types and digit encoding for the radix digit converter.
`default_nettype none

package itrd_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int RADIX_W        = 6;
	localparam int CHAR_W         = 7;

	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
	localparam logic [RADIX_W-1:0] DEC_DIGITS  = RADIX_W'(10);

	localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] CHAR_LETTER = CHAR_W'(87);

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {1'b0, d};
		if (d < DEC_DIGITS) begin
			return CHAR_ZERO + dx;
		end
		return CHAR_LETTER + dx;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/integer_to_radix_digits.sv -----
// Top level: converts an unsigned integer into radix digits, most significant first.
//
// Input channel: in_valid / in_ready with value. Output channel: out_valid /
// out_ready with digit_char, digit_value and last_digit, one beat per digit,
// most significant digit first; last_digit marks the least significant one.
// The base is written through radix_wr_en / radix_wr_data; the user must
// write it only while the block is idle, as the block does not enforce this.
// Writes below 2 store 2, above 36 store 36. Reset sets the base to 10.
// One value is in flight at a time: in_ready is high only while idle.
// Each digit costs one pass of the shared bit-serial divider, and its
// remainder is filed in the digit RAM as the pass ends. All divisions come
// before the first digit beat; each digit is then read from the RAM, loaded
// into the output register and offered for the handshake.
// Zero gives the single digit '0'. A stalled receiver holds the output
// register and the sequencer; the block returns to idle on the cycle after
// the last beat is taken.
`default_nettype none

`include "integer_to_radix_digits_macros.svh"

module integer_to_radix_digits #(
	parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          radix_wr_en,
	input  wire logic [itrd_pkg::RADIX_W-1:0]  radix_wr_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [VALUE_BITS-1:0]         value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [itrd_pkg::CHAR_W-1:0]   digit_char,
	output logic      [itrd_pkg::RADIX_W-1:0]  digit_value,
	output logic                               last_digit
);
	import itrd_pkg::*;

	localparam int AW = $clog2(VALUE_BITS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_RD,
		ST_LOAD,
		ST_OUT
	} state_t;

	state_t             state_q;
	logic [RADIX_W-1:0] radix_q;
	logic [AW-1:0]      cnt_q;
	logic [AW-1:0]      idx_q;

	logic                  div_start;
	logic [VALUE_BITS-1:0] div_dividend;
	logic [VALUE_BITS-1:0] div_quot;
	logic [RADIX_W-1:0]    div_rem;
	div_stat_t             div_stat;
	logic                  div_last;
	logic                  ram_we;
	logic [RADIX_W-1:0]    ram_rdata;

	assign in_ready     = state_q == ST_IDLE;
	assign div_last     = div_quot == '0;
	assign ram_we       = state_q == ST_DIV && div_stat.done;
	assign div_start    = (in_ready && in_valid) || (ram_we && !div_last);
	assign div_dividend = in_ready ? value : div_quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (radix_wr_en) begin
			if (radix_wr_data < RADIX_MIN) begin
				radix_q <= RADIX_MIN;
			end else if (radix_wr_data > RADIX_MAX) begin
				radix_q <= RADIX_MAX;
			end else begin
				radix_q <= radix_wr_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid   <= 1'b0;
			digit_char  <= '0;
			digit_value <= '0;
			last_digit  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						cnt_q <= cnt_q + AW'(1);
						if (div_last) begin
							idx_q   <= cnt_q;
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					digit_value <= ram_rdata;
					digit_char  <= digit_to_char(ram_rdata);
					last_digit  <= idx_q == '0;
					out_valid   <= 1'b1;
					state_q     <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						if (last_digit) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q - AW'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	itrd_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (radix_q),
		.quotient (div_quot),
		.remainder(div_rem),
		.stat     (div_stat)
	);

	itrd_ram #(
		.WIDTH(RADIX_W),
		.DEPTH(VALUE_BITS)
	) u_digits (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q),
		.wdata(div_rem),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	`ITRD_NEVER(a_ready_xor_valid, in_ready && out_valid, "input ready while a digit is pending")
	`ITRD_ASSERT(a_last_to_idle, out_valid && out_ready && last_digit |=> in_ready, "no idle after last digit")
	`ITRD_ASSERT(a_done_in_div, div_stat.done |-> state_q == ST_DIV, "divider done outside division")
	`ITRD_ASSERT(a_radix_range, radix_q >= RADIX_MIN && radix_q <= RADIX_MAX, "base out of range")

endmodule

`default_nettype wire

// ----- hw/rtl/itrd_ram.sv -----
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module itrd_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/itrd_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle by a small divisor.
`default_nettype none

`include "integer_to_radix_digits_macros.svh"

module itrd_div #(
	parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [VALUE_BITS-1:0]        dividend,
	input  wire logic [itrd_pkg::RADIX_W-1:0] divisor,
	output logic      [VALUE_BITS-1:0]        quotient,
	output logic      [itrd_pkg::RADIX_W-1:0] remainder,
	output itrd_pkg::div_stat_t               stat
);
	import itrd_pkg::*;

	localparam int SW = $clog2(VALUE_BITS);
	localparam logic [SW-1:0] LAST_STEP = SW'(VALUE_BITS - 1);

	logic [VALUE_BITS-1:0] q_q;
	logic [RADIX_W-1:0]    r_q;
	logic [SW-1:0]         step_q;
	logic                  busy_q;
	logic                  done_q;

	logic [RADIX_W:0] rs;
	logic [RADIX_W:0] diff;
	logic             ge;

	assign rs   = {r_q, q_q[VALUE_BITS-1]};
	assign diff = rs - {1'b0, divisor};
	assign ge   = rs >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			q_q    <= '0;
			r_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				q_q    <= dividend;
				r_q    <= '0;
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				q_q    <= {q_q[VALUE_BITS-2:0], ge};
				r_q    <= ge ? diff[RADIX_W-1:0] : rs[RADIX_W-1:0];
				step_q <= step_q + SW'(1);
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient  = q_q;
	assign remainder = r_q;
	assign stat      = '{busy: busy_q, done: done_q};

	`ITRD_NEVER(a_start_idle, start && busy_q, "divider started while busy")
	`ITRD_NEVER(a_done_not_busy, done_q && busy_q, "divider done while busy")
	`ITRD_ASSERT(a_last_step_done, busy_q && !start && step_q == LAST_STEP |=> done_q, "missing done")

endmodule

`default_nettype wire
